>>> design/tws_pkg.sv
// ----------------------------------------------------------------------------
// tws_pkg
// Shared types and constants for the three-way quick sorter.
// ----------------------------------------------------------------------------
package tws_pkg;

  localparam int unsigned MaxElems   = 64;
  localparam int unsigned ValueWidth = 32;
  localparam int unsigned WordWidth  = 32;

  typedef struct packed {
    logic signed [WordWidth-1:0] value;
    logic                        is_last;
  } in_word_t;

  typedef struct packed {
    logic signed [WordWidth-1:0] sorted_value;
    logic                        last_out;
    logic                        overflow;
  } out_word_t;

  // per-cycle command from the controller to every cell
  typedef struct packed {
    logic insert;
    logic shift;
  } cell_ctrl_t;

  typedef enum logic [2:0] {
    StLoad  = 3'b001,
    StDrain = 3'b010,
    StEmit  = 3'b100
  } state_e;

endpackage

>>> design/tws_cell.sv
// ----------------------------------------------------------------------------
// tws_cell
// One sorting cell: keeps the smaller of its held value and the incoming
// carry, passes the larger one to the right; shifts left while emitting.
// ----------------------------------------------------------------------------
module tws_cell
  import tws_pkg::*;
#(
  parameter int unsigned ValueWidth = tws_pkg::ValueWidth
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cell_ctrl_t            ctrl_i,
  input  logic                  carry_valid_i,
  input  logic [ValueWidth-1:0] carry_value_i,
  input  logic                  next_full_i,
  input  logic [ValueWidth-1:0] next_value_i,
  output logic                  carry_valid_o,
  output logic [ValueWidth-1:0] carry_value_o,
  output logic                  full_o,
  output logic [ValueWidth-1:0] value_o
);

  logic                  carry_valid_q, carry_valid_d;
  logic [ValueWidth-1:0] carry_value_q;
  logic                  full_q, full_d;
  logic [ValueWidth-1:0] value_q, value_d;
  logic                  take_carry;

  assign take_carry = $signed(carry_value_q) < $signed(value_q);

  always_comb begin
    carry_valid_d = ctrl_i.insert & carry_valid_i;
    full_d        = full_q;
    value_d       = value_q;
    carry_valid_o = 1'b0;
    carry_value_o = carry_value_q;
    if (ctrl_i.shift) begin
      full_d  = next_full_i;
      value_d = next_value_i;
    end else if (carry_valid_q) begin
      if (!full_q) begin
        full_d  = 1'b1;
        value_d = carry_value_q;
      end else if (take_carry) begin
        // smaller word settles here, the held one moves on
        value_d       = carry_value_q;
        carry_valid_o = 1'b1;
        carry_value_o = value_q;
      end else begin
        carry_valid_o = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      carry_valid_q <= 1'b0;
      full_q        <= 1'b0;
    end else begin
      carry_valid_q <= carry_valid_d;
      full_q        <= full_d;
    end
  end

  always_ff @(posedge clk_i) begin
    carry_value_q <= carry_value_i;
    value_q       <= value_d;
  end

  assign full_o  = full_q;
  assign value_o = value_q;

endmodule

>>> design/three_way_quick_sorter.sv
// ----------------------------------------------------------------------------
// three_way_quick_sorter
// Collects signed words until one marked last, then returns them in
// ascending order through a linear chain of insertion cells.
// ----------------------------------------------------------------------------
//  channel | direction | handshake               | payload
//  in      | input     | in_valid_i / in_ready_o | in_word_t  (value, is_last)
//  out     | output    | out_valid_o/out_ready_i | out_word_t (sorted_value,
//          |           |                         |   last_out, overflow)
//
//  loading takes one word per cycle; each word ripples one cell per cycle
//  after the last word the chain settles in a drain state, then one sorted
//  word leaves per cycle while out_ready_i is high
//  in_ready_o is low from the last word until the final result is taken
//  reset empties every cell; a stalled result holds in cell zero
// ----------------------------------------------------------------------------
module three_way_quick_sorter
  import tws_pkg::*;
#(
  parameter int unsigned MaxElements = tws_pkg::MaxElems,
  parameter int unsigned ValueWidth  = tws_pkg::ValueWidth
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_word_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_word_t out_data_o
);

  localparam int unsigned CntW = $clog2(MaxElements + 1);
  localparam int unsigned DrW  = $clog2(MaxElements);

  state_e          state_q, state_d;
  logic [CntW-1:0] count_q, count_d;
  logic [DrW-1:0]  drain_q, drain_d;
  logic            drop_q, drop_d;

  logic            in_acc, out_acc, has_room;
  cell_ctrl_t      ctrl;

  logic signed [63:0]    in_ext;
  logic signed [63:0]    out_ext;
  logic [ValueWidth-1:0] in_val;

  logic                  carry_valid [MaxElements];
  logic [ValueWidth-1:0] carry_value [MaxElements];
  logic                  full        [MaxElements+1];
  logic [ValueWidth-1:0] value       [MaxElements+1];

  assign in_ready_o  = (state_q == StLoad);
  assign out_valid_o = (state_q == StEmit);
  assign in_acc      = in_valid_i & in_ready_o;
  assign out_acc     = out_valid_o & out_ready_i;
  assign has_room    = count_q < CntW'(MaxElements);

  assign in_ext = 64'(in_data_i.value);
  assign in_val = in_ext[ValueWidth-1:0];

  assign ctrl.insert = ~out_valid_o;
  assign ctrl.shift  = out_acc;

  assign carry_valid[0] = in_acc & has_room;
  assign carry_value[0] = in_val;
  assign full[MaxElements]  = 1'b0;
  assign value[MaxElements] = '0;

  for (genvar i = 0; i < MaxElements; i++) begin : g_cell
    if (i < MaxElements - 1) begin : g_mid
      tws_cell #(.ValueWidth(ValueWidth)) u_cell (
        .clk_i,
        .rst_ni,
        .ctrl_i        (ctrl),
        .carry_valid_i (carry_valid[i]),
        .carry_value_i (carry_value[i]),
        .next_full_i   (full[i+1]),
        .next_value_i  (value[i+1]),
        .carry_valid_o (carry_valid[i+1]),
        .carry_value_o (carry_value[i+1]),
        .full_o        (full[i]),
        .value_o       (value[i])
      );
    end else begin : g_end
      // the count never lets a carry leave the final cell
      tws_cell #(.ValueWidth(ValueWidth)) u_cell (
        .clk_i,
        .rst_ni,
        .ctrl_i        (ctrl),
        .carry_valid_i (carry_valid[i]),
        .carry_value_i (carry_value[i]),
        .next_full_i   (full[i+1]),
        .next_value_i  (value[i+1]),
        .carry_valid_o (),
        .carry_value_o (),
        .full_o        (full[i]),
        .value_o       (value[i])
      );
    end
  end

  always_comb begin
    state_d = state_q;
    count_d = count_q;
    drain_d = drain_q;
    drop_d  = drop_q;
    case (state_q)
      StLoad: begin
        if (in_acc) begin
          if (has_room) begin
            count_d = count_q + CntW'(1);
          end else begin
            drop_d = 1'b1;
          end
          if (in_data_i.is_last) begin
            state_d = StDrain;
            drain_d = '0;
          end
        end
      end
      StDrain: begin
        drain_d = drain_q + DrW'(1);
        if (drain_q == DrW'(MaxElements - 1)) begin
          state_d = StEmit;
        end
      end
      StEmit: begin
        if (out_acc) begin
          count_d = count_q - CntW'(1);
          if (count_q == CntW'(1)) begin
            state_d = StLoad;
            drop_d  = 1'b0;
          end
        end
      end
      default: begin
        state_d = StLoad;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StLoad;
      count_q <= '0;
      drain_q <= '0;
      drop_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      drain_q <= drain_d;
      drop_q  <= drop_d;
    end
  end

  assign out_ext                 = 64'($signed(value[0]));
  assign out_data_o.sorted_value = out_ext[WordWidth-1:0];
  assign out_data_o.last_out     = (count_q == CntW'(1));
  assign out_data_o.overflow     = drop_q;

endmodule

>>> design/tws_checker.sv
// ----------------------------------------------------------------------------
// tws_checker
// Port-level checks for the three-way quick sorter, bound to the top level.
// ----------------------------------------------------------------------------
module tws_checker
  import tws_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_ready_o,
  input in_word_t  in_data_i,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input out_word_t out_data_o
);

  // a pending result is never withdrawn
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result withdrawn before it was taken");

  // loading and emitting never overlap
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input taken while results pending");

  // a word marked last closes the input
  a_last_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && in_data_i.is_last |=> !in_ready_o)
    else $error("input still open after last word");

  // final result ends the run
  a_run_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && out_data_o.last_out |=> !out_valid_o)
    else $error("result shown after the final one");

  // results come out in ascending signed order
  a_ascending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !out_data_o.last_out |=>
      out_valid_o && (out_data_o.sorted_value >= $past(out_data_o.sorted_value)))
    else $error("results out of order");

endmodule

bind three_way_quick_sorter tws_checker u_tws_checker (.*);

>>> verif/tb_three_way_quick_sorter.sv
// ----------------------------------------------------------------------------
// tb_three_way_quick_sorter
// Sends sets of signed words to the sorter and checks every returned word
// against a software sort of the same set, including the overflow flag when
// a set is larger than the store. Both handshakes idle at random outside the capacity test.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_three_way_quick_sorter;
  import tws_pkg::*;

  localparam int unsigned CycleLimit   = 200000;
  localparam int unsigned SettleCycles = 2 * MaxElems + 16;
  localparam int unsigned RandomWords  = 24;

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_ready_o;
  in_word_t  in_data_i   = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  out_word_t out_data_o;

  // words of the set being collected, and whether any were lost
  logic signed [WordWidth-1:0] held_vals[$];
  logic                        held_dropped = 1'b0;
  // sorted words still owed by the block, oldest first
  out_word_t                   pending_sorted_q[$];

  int unsigned mismatches  = 0;
  int unsigned cycle_count = 0;
  bit          no_idle     = 1'b0;

  three_way_quick_sorter dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("** three_way_quick_sorter: FAILED **");
      $finish;
    end
  end

  // collect one accepted word; a last word releases the sorted set
  function automatic void absorb_word(in_word_t w);
    out_word_t                   r;
    logic signed [WordWidth-1:0] key;
    int                          j;
    if (held_vals.size() < MaxElems) held_vals.push_back(w.value);
    else held_dropped = 1'b1;
    if (w.is_last) begin
      for (int i = 1; i < held_vals.size(); i++) begin
        key = held_vals[i];
        j = i;
        while (j > 0 && key < held_vals[j-1]) begin
          held_vals[j] = held_vals[j-1];
          j--;
        end
        held_vals[j] = key;
      end
      for (int i = 0; i < held_vals.size(); i++) begin
        r.sorted_value = held_vals[i];
        r.last_out     = (i == held_vals.size() - 1);
        r.overflow     = held_dropped;
        pending_sorted_q.push_back(r);
      end
      held_vals.delete();
      held_dropped = 1'b0;
    end
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) absorb_word(in_data_i);
  end

  always @(posedge clk_i) begin
    out_word_t want;
    out_ready_i <= no_idle || ($urandom_range(99) >= 12);
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_sorted_q.size() == 0) begin
        $error("unexpected word: sorted_value %0d", out_data_o.sorted_value);
        mismatches++;
      end else begin
        want = pending_sorted_q.pop_front();
        if (out_data_o.sorted_value !== want.sorted_value) begin
          $error("sorted_value: expected %0d, got %0d",
                 want.sorted_value, out_data_o.sorted_value);
          mismatches++;
        end
        if (out_data_o.last_out !== want.last_out) begin
          $error("last_out: expected %0b, got %0b", want.last_out, out_data_o.last_out);
          mismatches++;
        end
        if (out_data_o.overflow !== want.overflow) begin
          $error("overflow: expected %0b, got %0b", want.overflow, out_data_o.overflow);
          mismatches++;
        end
      end
    end
  end

  // valid stays up after a word is taken so the next word can follow at once
  task automatic send_word(input logic signed [WordWidth-1:0] v, input logic last);
    in_word_t w;
    w.value   = v;
    w.is_last = last;
    if (!no_idle && $urandom_range(99) < 12) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < 12);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= w;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic send_set(input logic signed [WordWidth-1:0] vals[$]);
    foreach (vals[i]) send_word(vals[i], i == vals.size() - 1);
  endtask

  // queue is sampled on the falling edge, clear of the monitors
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (pending_sorted_q.size() != 0);
    @(posedge clk_i);
  endtask

  function automatic logic signed [WordWidth-1:0] pick_value(
      logic signed [WordWidth-1:0] prev);
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 60) return $urandom;
    if (sel < 85) return int'($urandom_range(6)) - 3;
    return prev;
  endfunction

  task automatic test_single_word();
    send_word(32'sh8000_0000, 1'b1);
  endtask

  task automatic test_extremes();
    logic signed [WordWidth-1:0] vals[$];
    vals = {32'sh7fff_ffff, 32'sh8000_0000, 32'sh0, -32'sd1, 32'sd1,
            32'sh5555_5555, 32'shaaaa_aaaa};
    send_set(vals);
  endtask

  task automatic test_duplicates();
    logic signed [WordWidth-1:0] vals[$];
    vals = {32'sd3, 32'sd3, -32'sd2, 32'sd3, -32'sd2};
    send_set(vals);
    wait_drained();
  endtask

  task automatic test_ordered_runs();
    logic signed [WordWidth-1:0] vals[$];
    vals = {32'sd4, 32'sd3, 32'sd2, 32'sd1, 32'sd0};
    send_set(vals);
    vals = {-32'sd9, -32'sd5, 32'sd0, 32'sd5, 32'sd9};
    send_set(vals);
  endtask

  // full store, then one word too many with the last word dropped
  task automatic test_capacity();
    logic signed [WordWidth-1:0] v;
    no_idle = 1'b1;
    v = '0;
    for (int unsigned k = 0; k < MaxElems; k++) begin
      v = pick_value(v);
      send_word(v, k == MaxElems - 1);
    end
    wait_drained();
    for (int unsigned k = 0; k <= MaxElems; k++) begin
      v = pick_value(v);
      send_word(v, k == MaxElems);
    end
    wait_drained();
    no_idle = 1'b0;
  endtask

  task automatic test_random_sets();
    int unsigned                 sent;
    int unsigned                 size;
    int unsigned                 sel;
    logic signed [WordWidth-1:0] v;
    sent = 0;
    v = '0;
    while (sent < RandomWords) begin
      sel = $urandom_range(99);
      if (sel < 70) size = $urandom_range(8, 1);
      else if (sel < 92) size = $urandom_range(24, 9);
      else size = $urandom_range(MaxElems + 3, 25);
      if (size > RandomWords - sent) size = RandomWords - sent;
      for (int unsigned k = 0; k < size; k++) begin
        v = pick_value(v);
        send_word(v, k == size - 1);
      end
      sent += size;
      if ($urandom_range(9) == 0) wait_drained();
    end
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_single_word();
    test_extremes();
    test_duplicates();
    test_ordered_runs();
    test_capacity();
    test_random_sets();
    wait_drained();
    repeat (SettleCycles) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("** three_way_quick_sorter: PASSED **");
    end else begin
      $display("** three_way_quick_sorter: FAILED **");
    end
    $finish;
  end

endmodule

>>> files.f
design/tws_pkg.sv
design/tws_cell.sv
design/three_way_quick_sorter.sv
design/tws_checker.sv
verif/tb_three_way_quick_sorter.sv
